>>> rtl/core/level_median_expression_estimator_unit_defines.svh
// Assertion macros for the level median expression estimator.
`ifndef LEVEL_MEDIAN_EXPRESSION_ESTIMATOR_UNIT_DEFINES_SVH
`define LEVEL_MEDIAN_EXPRESSION_ESTIMATOR_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define LMEE_ASSERT_NOW(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("lmee: same-cycle check failed");
// next-cycle implication
`define LMEE_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("lmee: next-cycle check failed");
`else
`define LMEE_ASSERT_NOW(label, ck, rn, ante, cons)
`define LMEE_ASSERT_NEXT(label, ck, rn, ante, cons)
`endif

`endif

>>> rtl/core/lmee_pkg.sv
`default_nettype none

package lmee_pkg;

  localparam int FRACTION_BITS = 16;

  localparam int DATA_W    = 16;
  localparam int RUN_W     = 40;
  localparam int CNT_W     = 16 + FRACTION_BITS;      // corrected count, diff
  localparam int MED_W     = 15 + FRACTION_BITS;      // median position
  localparam int PROD_W    = 32;                      // total * fpr
  localparam int FP_LSHIFT = (FRACTION_BITS >= 16) ? (FRACTION_BITS - 16) : 0;
  localparam int FP_RSHIFT = (FRACTION_BITS >= 16) ? 0 : (16 - FRACTION_BITS);
  localparam int EXPSH_W   = PROD_W + FP_LSHIFT;
  localparam int PROD2_W   = MED_W + DATA_W;          // num * span
  localparam int PDIV_W    = PROD2_W + 1;             // num * span + corr - 1
  localparam int DIV_W     = 16 + FRACTION_BITS;      // divider datapath
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     rem0;   // initial partial remainder, below den
    logic [DIV_W-1:0]     quo0;   // dividend low bits, left aligned
    logic [DIV_W-1:0]     den;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/lmee_ifs.sv
`default_nettype none

interface lmee_in_if;
  logic                       valid;
  logic                       ready;
  logic [lmee_pkg::DATA_W-1:0] hit_count;
  logic [lmee_pkg::DATA_W-1:0] minimiser_total;
  logic [lmee_pkg::DATA_W-1:0] fp_rate;
  logic [lmee_pkg::DATA_W-1:0] level_threshold;
  logic [lmee_pkg::DATA_W-1:0] upper_threshold;
  logic                       top_level;
  logic                       last_level;
  logic                       bin_deleted;
  logic [lmee_pkg::DATA_W-1:0] norm_divisor;

  modport source (
    output valid, hit_count, minimiser_total, fp_rate, level_threshold,
           upper_threshold, top_level, last_level, bin_deleted, norm_divisor,
    input  ready
  );
  modport sink (
    input  valid, hit_count, minimiser_total, fp_rate, level_threshold,
           upper_threshold, top_level, last_level, bin_deleted, norm_divisor,
    output ready
  );
endinterface

interface lmee_out_if;
  logic                       valid;
  logic                       ready;
  logic [lmee_pkg::DATA_W-1:0] estimate;
  logic                       divide_by_zero;

  modport source (output valid, estimate, divide_by_zero, input ready);
  modport sink   (input valid, estimate, divide_by_zero, output ready);
endinterface

`default_nettype wire

>>> rtl/core/level_median_expression_estimator_unit.sv
// Level median expression estimator.
// in_ch (valid/ready) carries one bin's hit count per level, highest level
// first; top_level opens an experiment, last_level closes it. out_ch carries
// one transaction per last_level item: the estimate and the zero-divisor flag.
// cfg_we/cfg_wdata write normalize_enable; write it only while idle.
// Each item runs on one shared radix-2 divider under a small sequencer, and
// in_ch.ready is low until the item is done. With F = FRACTION_BITS:
//   deleted bin or estimate already fixed: straight to the finish state
//   level that only adds to the running sum: count correction divide
//     (skipped when the corrected count saturates)
//   level that fixes the estimate: count correction, then up to two more
//     divides (count correction F+16 divider steps, interpolation 16 steps,
//      normalization 16 steps, plus setup states around each).
// The result becomes valid in the same cycle in_ch.ready comes back high.
// The result sits in an output register; the next item is taken while it
// waits. A last_level item that finds the register still full waits at its
// end until out_ch.ready frees it.
// Reset (rst_n low, synchronous) clears the sum, estimate, flags, the
// output valid and normalize_enable; no clearing pass is needed.
`default_nettype none

`include "level_median_expression_estimator_unit_defines.svh"

module level_median_expression_estimator_unit (
  input  logic              clk,
  input  logic              rst_n,
  lmee_in_if.sink           in_ch,
  lmee_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);

  localparam int F = lmee_pkg::FRACTION_BITS;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b00000000001,
    ST_MUL1   = 11'b00000000010,
    ST_DIFF   = 11'b00000000100,
    ST_DIV1   = 11'b00000001000,
    ST_CHECK  = 11'b00000010000,
    ST_MUL2   = 11'b00000100000,
    ST_LOAD2  = 11'b00001000000,
    ST_DIV2   = 11'b00010000000,
    ST_NORM   = 11'b00100000000,
    ST_DIV3   = 11'b01000000000,
    ST_FINISH = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  // experiment state
  logic                         norm_en_r;
  logic [lmee_pkg::RUN_W-1:0]   running_r, running_nxt;
  logic [lmee_pkg::DATA_W-1:0]  cur_est_r, cur_est_nxt;
  logic                         zdiv_r, zdiv_nxt;
  logic                         found_r, found_nxt;

  // latched item
  logic [lmee_pkg::DATA_W-1:0]  count_r, count_nxt;
  logic [lmee_pkg::DATA_W-1:0]  total_r, total_nxt;
  logic [lmee_pkg::DATA_W-1:0]  fpr_r, fpr_nxt;
  logic [lmee_pkg::DATA_W-1:0]  level_r, level_nxt;
  logic [lmee_pkg::DATA_W-1:0]  upper_r, upper_nxt;
  logic                         top_r, top_nxt;
  logic                         last_r, last_nxt;
  logic [lmee_pkg::DATA_W-1:0]  divisor_r, divisor_nxt;

  // datapath intermediates
  logic [lmee_pkg::PROD_W-1:0]  prod_r, prod_nxt;
  logic [lmee_pkg::CNT_W-1:0]   corr_r, corr_nxt;
  logic [lmee_pkg::PROD2_W-1:0] prod2_r, prod2_nxt;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  logic [lmee_pkg::DATA_W-1:0]  out_est_r, out_est_nxt;
  logic                         out_dbz_r, out_dbz_nxt;

  lmee_pkg::div_req_t div_req;
  lmee_pkg::div_rsp_t div_rsp;

  lmee_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // count correction: diff = count<<F - total*fpr (rescaled), den = 1 - fpr
  logic [16:0]                  den1;
  logic [lmee_pkg::CNT_W-1:0]   scaled;
  logic [lmee_pkg::EXPSH_W-1:0] exp_sh;
  logic [lmee_pkg::CNT_W-1:0]   expected;
  logic [lmee_pkg::CNT_W-1:0]   diff;

  assign den1     = 17'h10000 - 17'(fpr_r);
  assign scaled   = lmee_pkg::CNT_W'(count_r) << F;
  assign exp_sh   = lmee_pkg::EXPSH_W'(prod_r) << lmee_pkg::FP_LSHIFT;
  assign expected = lmee_pkg::CNT_W'(exp_sh >> lmee_pkg::FP_RSHIFT);
  assign diff     = (scaled > expected) ? (scaled - expected) : '0;

  // median test and interpolation operands
  logic [lmee_pkg::RUN_W:0]    sum;
  logic [lmee_pkg::RUN_W:0]    median_ext;
  logic [lmee_pkg::MED_W-1:0]  num;
  logic [lmee_pkg::DATA_W-1:0] span;
  logic [lmee_pkg::PDIV_W-1:0] pdiv;
  logic [lmee_pkg::DATA_W-1:0] q;
  logic                        div_wait;

  assign sum        = {1'b0, running_r} + (lmee_pkg::RUN_W + 1)'(corr_r);
  assign median_ext = (lmee_pkg::RUN_W + 1)'(total_r) << (F - 1);
  assign num        = lmee_pkg::MED_W'(median_ext - {1'b0, running_r});
  assign span       = upper_r - level_r;
  // ceil(num*span/corr) as floor((num*span + corr - 1)/corr)
  assign pdiv       = lmee_pkg::PDIV_W'(prod2_r) + lmee_pkg::PDIV_W'(corr_r)
                      - lmee_pkg::PDIV_W'(1);
  assign q          = div_rsp.quo[lmee_pkg::DATA_W-1:0];
  assign div_wait   = (state_r == ST_DIV1) || (state_r == ST_DIV2) || (state_r == ST_DIV3);

  assign in_ch.ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    running_nxt = running_r;
    cur_est_nxt = cur_est_r;
    zdiv_nxt    = zdiv_r;
    found_nxt   = found_r;
    count_nxt   = count_r;
    total_nxt   = total_r;
    fpr_nxt     = fpr_r;
    level_nxt   = level_r;
    upper_nxt   = upper_r;
    top_nxt     = top_r;
    last_nxt    = last_r;
    divisor_nxt = divisor_r;
    prod_nxt    = prod_r;
    corr_nxt    = corr_r;
    prod2_nxt   = prod2_r;
    out_est_nxt = out_est_r;
    out_dbz_nxt = out_dbz_r;
    div_req     = '0;

    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          count_nxt   = in_ch.hit_count;
          total_nxt   = in_ch.minimiser_total;
          fpr_nxt     = in_ch.fp_rate;
          level_nxt   = in_ch.level_threshold;
          upper_nxt   = in_ch.upper_threshold;
          top_nxt     = in_ch.top_level;
          last_nxt    = in_ch.last_level;
          divisor_nxt = in_ch.norm_divisor;
          // new experiment: clear before the item acts
          if (in_ch.top_level) begin
            running_nxt = '0;
            cur_est_nxt = '0;
            zdiv_nxt    = 1'b0;
            found_nxt   = 1'b0;
          end
          if (in_ch.bin_deleted || (found_r && !in_ch.top_level)) begin
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_MUL1;
          end
        end
      end
      ST_MUL1: begin
        prod_nxt  = lmee_pkg::PROD_W'(total_r) * lmee_pkg::PROD_W'(fpr_r);
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        // quotient overflows the count width iff diff >= den << F
        if ((diff >> F) >= lmee_pkg::CNT_W'(den1)) begin
          corr_nxt  = {lmee_pkg::CNT_W{1'b1}};
          state_nxt = ST_CHECK;
        end else begin
          div_req.start = 1'b1;
          div_req.rem0  = lmee_pkg::DIV_W'(diff >> F);
          div_req.quo0  = {diff[F-1:0], 16'h0000};
          div_req.den   = lmee_pkg::DIV_W'(den1);
          div_req.steps = lmee_pkg::DIV_CNT_W'(lmee_pkg::CNT_W);
          state_nxt     = ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (div_rsp.done) begin
          corr_nxt  = lmee_pkg::CNT_W'(div_rsp.quo);
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sum >= median_ext) begin
          found_nxt = 1'b1;
          state_nxt = ST_NORM;
          if (top_r) begin
            cur_est_nxt = level_r;
          end else if (upper_r <= level_r) begin
            cur_est_nxt = level_r;
          end else if ((median_ext <= {1'b0, running_r}) || (corr_r == '0)) begin
            cur_est_nxt = upper_r;
          end else begin
            state_nxt = ST_MUL2;
          end
        end else begin
          running_nxt = sum[lmee_pkg::RUN_W] ? {lmee_pkg::RUN_W{1'b1}}
                                             : sum[lmee_pkg::RUN_W-1:0];
          state_nxt   = ST_FINISH;
        end
      end
      ST_MUL2: begin
        prod2_nxt = lmee_pkg::PROD2_W'(num) * lmee_pkg::PROD2_W'(span);
        state_nxt = ST_LOAD2;
      end
      ST_LOAD2: begin
        // quotient of 2^16 or more is past any span: clamp to level
        if ((pdiv >> 16) >= lmee_pkg::PDIV_W'(corr_r)) begin
          cur_est_nxt = level_r;
          state_nxt   = ST_NORM;
        end else begin
          div_req.start = 1'b1;
          div_req.rem0  = lmee_pkg::DIV_W'(pdiv >> 16);
          div_req.quo0  = {pdiv[15:0], {F{1'b0}}};
          div_req.den   = lmee_pkg::DIV_W'(corr_r);
          div_req.steps = lmee_pkg::DIV_CNT_W'(16);
          state_nxt     = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (div_rsp.done) begin
          cur_est_nxt = (q >= span) ? level_r : (upper_r - q);
          state_nxt   = ST_NORM;
        end
      end
      ST_NORM: begin
        if (norm_en_r) begin
          if (divisor_r == '0) begin
            zdiv_nxt  = 1'b1;
            state_nxt = ST_FINISH;
          end else begin
            div_req.start = 1'b1;
            div_req.rem0  = '0;
            div_req.quo0  = {cur_est_r, {F{1'b0}}};
            div_req.den   = lmee_pkg::DIV_W'(divisor_r);
            div_req.steps = lmee_pkg::DIV_CNT_W'(16);
            state_nxt     = ST_DIV3;
          end
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_DIV3: begin
        if (div_rsp.done) begin
          cur_est_nxt = q;
          state_nxt   = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || out_ch.ready) begin
          // output register free (or freed this cycle): load the result
          out_valid_nxt = 1'b1;
          out_est_nxt   = cur_est_r;
          out_dbz_nxt   = zdiv_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      norm_en_r   <= 1'b0;
      running_r   <= '0;
      cur_est_r   <= '0;
      zdiv_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      running_r   <= running_nxt;
      cur_est_r   <= cur_est_nxt;
      zdiv_r      <= zdiv_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        norm_en_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    count_r   <= count_nxt;
    total_r   <= total_nxt;
    fpr_r     <= fpr_nxt;
    level_r   <= level_nxt;
    upper_r   <= upper_nxt;
    top_r     <= top_nxt;
    last_r    <= last_nxt;
    divisor_r <= divisor_nxt;
    prod_r    <= prod_nxt;
    corr_r    <= corr_nxt;
    prod2_r   <= prod2_nxt;
    out_est_r <= out_est_nxt;
    out_dbz_r <= out_dbz_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.estimate       = out_est_r;
  assign out_ch.divide_by_zero = out_dbz_r;

  // block goes busy right after taking a transaction
  `LMEE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  // divider is never restarted mid-operation
  `LMEE_ASSERT_NOW(a_div_start_free, clk, rst_n, div_req.start, !div_rsp.busy)
  // divider completion only lands in a wait state
  `LMEE_ASSERT_NOW(a_div_done_wait, clk, rst_n, div_rsp.done, div_wait)

endmodule

`default_nettype wire

>>> rtl/core/lmee_div.sv
`default_nettype none

// Restoring radix-2 divider, one quotient bit per cycle.
module lmee_div (
  input  logic               clk,
  input  logic               rst_n,
  input  lmee_pkg::div_req_t req,
  output lmee_pkg::div_rsp_t rsp
);

  logic [lmee_pkg::DIV_W-1:0]     rem_r, rem_nxt;
  logic [lmee_pkg::DIV_W-1:0]     quo_r, quo_nxt;
  logic [lmee_pkg::DIV_W-1:0]     den_r, den_nxt;
  logic [lmee_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;

  logic [lmee_pkg::DIV_W:0] trial;
  logic [lmee_pkg::DIV_W:0] trial_sub;
  logic                     ge;

  assign trial     = {rem_r, quo_r[lmee_pkg::DIV_W-1]};
  assign ge        = trial >= {1'b0, den_r};
  assign trial_sub = trial - {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = req.rem0;
      quo_nxt  = req.quo0;
      den_nxt  = req.den;
      cnt_nxt  = req.steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // remainder stays below den, so the top bit drops
      rem_nxt = ge ? trial_sub[lmee_pkg::DIV_W-1:0] : trial[lmee_pkg::DIV_W-1:0];
      quo_nxt = {quo_r[lmee_pkg::DIV_W-2:0], ge};
      cnt_nxt = cnt_r - lmee_pkg::DIV_CNT_W'(1);
      if (cnt_r == lmee_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

`default_nettype wire

>>> tb/sv/tb_level_median_expression_estimator_unit.sv
module tb_level_median_expression_estimator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_W        = lmee_pkg::DATA_W;
  localparam int RUN_W         = lmee_pkg::RUN_W;
  localparam int CNT_W         = lmee_pkg::CNT_W;
  localparam int FRACTION_BITS = lmee_pkg::FRACTION_BITS;
  localparam int FP_LSHIFT     = lmee_pkg::FP_LSHIFT;
  localparam int FP_RSHIFT     = lmee_pkg::FP_RSHIFT;

  // Run length and pacing.
  localparam int          RANDOM_PHASES       = 4;
  localparam int          ITEMS_PER_PHASE     = 388;
  localparam int          SETTLE_CYCLES       = 120;     // slowest item plus output reg
  localparam int          BACKPRESSURE_CYCLES = 1500;    // long sink hold-off
  localparam int          BACKPRESSURE_AFTER  = 60;      // results seen before the hold-off
  localparam longint      CYCLE_LIMIT         = 1000000;
  localparam int          N_DIRECTED          = 26;

  localparam longint unsigned RUN_LIMIT = (64'd1 << RUN_W) - 64'd1;
  localparam longint unsigned HITS_MAX  = (64'd1 << CNT_W) - 64'd1;

  // One level transaction on the input channel.
  typedef struct packed {
    logic [DATA_W-1:0] hit_count;
    logic [DATA_W-1:0] minimiser_total;
    logic [DATA_W-1:0] fp_rate;
    logic [DATA_W-1:0] level_threshold;
    logic [DATA_W-1:0] upper_threshold;
    logic              top_level;
    logic              last_level;
    logic              bin_deleted;
    logic [DATA_W-1:0] norm_divisor;
  } level_item_t;

  // One result transaction on the output channel.
  typedef struct packed {
    logic [DATA_W-1:0] estimate;
    logic              divide_by_zero;
  } estimate_t;

  // Directed stimulus row. norm is the normalize_enable setting the row runs
  // under; when fixed is set, est/dbz are the known answer for a last level.
  typedef struct {
    int norm;
    int count;
    int total;
    int fpr;
    int level;
    int upper;
    int top;
    int last;
    int del;
    int divisor;
    int fixed;
    int est;
    int dbz;
  } directed_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  lmee_in_if  in_ch ();
  lmee_out_if out_ch ();

  level_median_expression_estimator_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Estimator state as the testbench sees it.
  longint unsigned   sum_acc;        // corrected hits so far, Q.F
  logic [DATA_W-1:0] est_held;
  logic              zero_div_flag;
  logic              est_fixed;      // estimate found for this experiment
  logic              norm_on;        // mirror of normalize_enable

  estimate_t pending_estimates[$];

  int     burst_left   = 0;
  int     items_sent   = 0;
  int     results_seen = 0;
  int     mismatches   = 0;
  longint cycle_count  = 0;

  //   norm count  total  fpr    level  upper  top last del div    fixed est    dbz
  directed_row_t directed_rows [N_DIRECTED] = '{
    // after reset, no top level, deleted last level: nothing found
    '{0,   0,     0,     0,     0,     0,     0,  1,   1,  0,     1,    0,     0},
    // zero total: median is zero, found at top level
    '{0,   0,     0,     0,     65535, 0,     1,  1,   0,  0,     1,    65535, 0},
    // full count and total, lowest threshold
    '{0,   65535, 65535, 0,     0,     65535, 1,  1,   0,  65535, 1,    0,     0},
    // no hits at all: never reached
    '{0,   0,     65535, 0,     1234,  0,     1,  1,   0,  0,     1,    0,     0},
    // fpr at max: corrected count saturates
    '{0,   65535, 0,     65535, 777,   0,     1,  1,   0,  0,     1,    777,   0},
    // single deleted level
    '{0,   65535, 1,     0,     10,    0,     1,  1,   1,  0,     1,    0,     0},
    // three levels, crossing on the third (interpolated)
    '{0,   10,    100,   0,     800,   0,     1,  0,   0,  0,     0,    0,     0},
    '{0,   20,    100,   0,     600,   800,   0,  0,   0,  0,     0,    0,     0},
    '{0,   40,    100,   0,     400,   600,   0,  1,   0,  0,     0,    0,     0},
    // upper threshold not above level threshold
    '{0,   0,     100,   0,     500,   0,     1,  0,   0,  0,     0,    0,     0},
    '{0,   100,   100,   0,     900,   300,   0,  1,   0,  0,     0,    0,     0},
    // total shrinks so the sum is already past the median
    '{0,   40,    100,   0,     500,   0,     1,  0,   0,  0,     0,    0,     0},
    '{0,   0,     20,    0,     300,   500,   0,  1,   0,  0,     0,    0,     0},
    // found at the top, later level changes nothing
    '{0,   10,    10,    0,     50,    0,     1,  0,   0,  0,     0,    0,     0},
    '{0,   0,     10,    0,     30,    50,    0,  1,   0,  0,     0,    0,     0},
    // deleted bin in the middle of an experiment
    '{0,   30,    100,   0,     90,    0,     1,  0,   0,  0,     0,    0,     0},
    '{0,   65535, 100,   0,     70,    90,    0,  0,   1,  0,     0,    0,     0},
    '{0,   30,    100,   0,     50,    70,    0,  1,   0,  0,     0,    0,     0},
    // false positive correction, then a negative difference
    '{0,   600,   1000,  32768, 9,     0,     1,  0,   0,  0,     0,    0,     0},
    '{0,   400,   1000,  32768, 5,     9,     0,  1,   0,  0,     0,    0,     0},
    // normalization: zero divisor, plain divide, divisor extremes
    '{1,   100,   100,   0,     1000,  0,     1,  1,   0,  0,     1,    1000,  1},
    '{1,   100,   100,   0,     1000,  0,     1,  1,   0,  7,     1,    142,   0},
    '{1,   100,   100,   0,     65535, 0,     1,  1,   0,  65535, 1,    1,     0},
    '{1,   100,   100,   0,     65535, 0,     1,  1,   0,  1,     1,    65535, 0},
    // normalization of an interpolated estimate
    '{1,   10,    100,   0,     800,   0,     1,  0,   0,  0,     0,    0,     0},
    '{1,   90,    100,   0,     600,   800,   0,  1,   0,  3,     0,    0,     0}
  };

  // ---------------------------------------------------------------------------
  // Estimator predictor
  // ---------------------------------------------------------------------------

  // Hit count with the expected false positives taken out, rescaled by
  // 1/(1-fpr). Q.F, saturating.
  function automatic longint unsigned corrected_hits(level_item_t it);
    longint unsigned total, fpr, fp_hits, scaled, excess, c;
    total   = it.minimiser_total;
    fpr     = it.fp_rate;
    fp_hits = ((total * fpr) << FP_LSHIFT) >> FP_RSHIFT;
    scaled  = it.hit_count;
    scaled  = scaled << FRACTION_BITS;
    excess  = (scaled > fp_hits) ? scaled - fp_hits : 64'd0;
    c       = (excess << 16) / (64'd65536 - fpr);
    return (c > HITS_MAX) ? HITS_MAX : c;
  endfunction

  // Linear step down from the upper threshold, clamped at this level.
  function automatic logic [DATA_W-1:0] interpolated_level(
    longint unsigned median, longint unsigned corr,
    longint unsigned level, longint unsigned upper);
    longint unsigned span, shortfall, steps;
    if (upper <= level) return DATA_W'(level);
    if (median <= sum_acc || corr == 64'd0) return DATA_W'(upper);
    span      = upper - level;
    shortfall = median - sum_acc;
    steps     = (shortfall * span + corr - 64'd1) / corr;
    if (steps >= span) return DATA_W'(level);
    return DATA_W'(upper - steps);
  endfunction

  // Apply one accepted level to the state; emits is set on a last level.
  task automatic advance_estimator(input level_item_t it, output bit emits,
                                   output estimate_t res);
    longint unsigned   corr, median, total_sum, lvl, upr;
    logic [DATA_W-1:0] est;
    if (it.top_level) begin
      sum_acc       = 64'd0;
      est_held      = '0;
      zero_div_flag = 1'b0;
      est_fixed     = 1'b0;
    end
    if (!it.bin_deleted && !est_fixed) begin
      corr      = corrected_hits(it);
      median    = it.minimiser_total;
      median    = median << (FRACTION_BITS - 1);
      total_sum = sum_acc + corr;
      if (total_sum >= median) begin
        lvl = it.level_threshold;
        upr = it.upper_threshold;
        est = it.top_level ? it.level_threshold
                           : interpolated_level(median, corr, lvl, upr);
        if (norm_on) begin
          if (it.norm_divisor == '0) zero_div_flag = 1'b1;
          else est = est / it.norm_divisor;
        end
        est_held  = est;
        est_fixed = 1'b1;
      end else begin
        sum_acc = (total_sum > RUN_LIMIT) ? RUN_LIMIT : total_sum;
      end
    end
    emits              = it.last_level;
    res.estimate       = est_held;
    res.divide_by_zero = zero_div_flag;
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset, cycle limit
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop if the run hangs (handshake never completes, results missing).
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Source side
  // ---------------------------------------------------------------------------

  // Offer one level transaction. The sender runs in bursts of random length;
  // a new burst may open with a gap with valid low. The expectation is queued
  // at the accepting edge, from the predictor unless the row gives a fixed
  // answer.
  task automatic send_level(input level_item_t it, input bit fixed,
                            input estimate_t fixed_res);
    int        gap;
    bit        emits;
    estimate_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid           <= 1'b1;
    in_ch.hit_count       <= it.hit_count;
    in_ch.minimiser_total <= it.minimiser_total;
    in_ch.fp_rate         <= it.fp_rate;
    in_ch.level_threshold <= it.level_threshold;
    in_ch.upper_threshold <= it.upper_threshold;
    in_ch.top_level       <= it.top_level;
    in_ch.last_level      <= it.last_level;
    in_ch.bin_deleted     <= it.bin_deleted;
    in_ch.norm_divisor    <= it.norm_divisor;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    advance_estimator(it, emits, res);
    if (emits) pending_estimates.insert(pending_estimates.size(), fixed ? fixed_res : res);
    items_sent++;
  endtask

  // Block is idle once every result is back and the last item (which may
  // cause no result) has had time to finish.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_normalize(input bit en);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    @(posedge clk);
    cfg_we    <= 1'b0;
    norm_on   = en;
  endtask

  // One experiment: levels from high threshold down, counts sized so the
  // median is crossed somewhere along the way. Now and then the opening or
  // closing level is dropped, or thresholds come out of order.
  task automatic run_experiment();
    level_item_t       it;
    int                levels, cap;
    logic [DATA_W-1:0] total, fpr, thr, prev_thr;
    bit                drop_top, drop_last;
    levels = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
    case ($urandom_range(0, 9))
      0:       total = '0;
      1:       total = '1;
      2, 3:    total = DATA_W'($urandom_range(1, 64));
      default: total = DATA_W'($urandom_range(1, 65535));
    endcase
    case ($urandom_range(0, 5))
      0:       fpr = '0;
      1:       fpr = DATA_W'($urandom);
      default: fpr = DATA_W'($urandom_range(0, 4000));
    endcase
    drop_top  = ($urandom_range(0, 11) == 0);
    drop_last = ($urandom_range(0, 11) == 0);
    cap = (2 * int'(total)) / levels + 2;
    if (cap > 65535) cap = 65535;
    thr      = DATA_W'($urandom);
    prev_thr = thr;
    for (int lv = 0; lv < levels; lv++) begin
      it.hit_count       = DATA_W'($urandom_range(0, cap));
      it.minimiser_total = total;
      it.fp_rate         = fpr;
      it.level_threshold = thr;
      it.upper_threshold = (lv == 0 || $urandom_range(0, 15) == 0) ? DATA_W'($urandom)
                                                                  : prev_thr;
      it.top_level       = (lv == 0) && !drop_top;
      it.last_level      = (lv == levels - 1) && !drop_last;
      it.bin_deleted     = ($urandom_range(0, 7) == 0);
      case ($urandom_range(0, 9))
        0:       it.norm_divisor = '0;
        1:       it.norm_divisor = '1;
        default: it.norm_divisor = DATA_W'($urandom_range(1, 300));
      endcase
      send_level(it, 1'b0, '0);
      prev_thr = thr;
      thr      = thr - DATA_W'($urandom_range(0, int'(thr) / (levels - lv)));
    end
  endtask

  // Main sequence: reset, directed rows, random phases, drain, verdict.
  initial begin : stimulus
    level_item_t   it;
    estimate_t     fixed_res;
    directed_row_t r;
    int            phase_end;

    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_wdata             <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.hit_count       <= '0;
    in_ch.minimiser_total <= '0;
    in_ch.fp_rate         <= '0;
    in_ch.level_threshold <= '0;
    in_ch.upper_threshold <= '0;
    in_ch.top_level       <= 1'b0;
    in_ch.last_level      <= 1'b0;
    in_ch.bin_deleted     <= 1'b0;
    in_ch.norm_divisor    <= '0;
    sum_acc       = 64'd0;
    est_held      = '0;
    zero_div_flag = 1'b0;
    est_fixed     = 1'b0;
    norm_on       = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_normalize(1'b0);

    // Directed part: reconfigure only where the row's setting changes.
    for (int i = 0; i < N_DIRECTED; i++) begin
      r = directed_rows[i];
      if ((r.norm != 0) != norm_on) write_normalize(r.norm != 0);
      it.hit_count          = DATA_W'(r.count);
      it.minimiser_total    = DATA_W'(r.total);
      it.fp_rate            = DATA_W'(r.fpr);
      it.level_threshold    = DATA_W'(r.level);
      it.upper_threshold    = DATA_W'(r.upper);
      it.top_level          = (r.top != 0);
      it.last_level         = (r.last != 0);
      it.bin_deleted        = (r.del != 0);
      it.norm_divisor       = DATA_W'(r.divisor);
      fixed_res.estimate       = DATA_W'(r.est);
      fixed_res.divide_by_zero = (r.dbz != 0);
      send_level(it, r.fixed != 0, fixed_res);
    end

    // Random part: alternate normalize_enable per phase. Mostly well formed
    // experiments, the rest raw transactions with every field random.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_normalize(ph[0]);
      phase_end = items_sent + ITEMS_PER_PHASE;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 7) == 0) begin
          it.hit_count       = DATA_W'($urandom);
          it.minimiser_total = DATA_W'($urandom);
          it.fp_rate         = DATA_W'($urandom);
          it.level_threshold = DATA_W'($urandom);
          it.upper_threshold = DATA_W'($urandom);
          it.top_level       = 1'($urandom_range(0, 1));
          it.last_level      = 1'($urandom_range(0, 1));
          it.bin_deleted     = 1'($urandom_range(0, 1));
          it.norm_divisor    = DATA_W'($urandom);
          send_level(it, 1'b0, '0);
        end else begin
          run_experiment();
        end
      end
    end

    wait_idle();
    if (mismatches == 0 && pending_estimates.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sink side
  // ---------------------------------------------------------------------------

  // Ready steps through a random 16-bit mask, redrawn per window; a quarter of the
  // windows never stall. Once, after some results, ready is held low for a
  // long stretch so the output register fills and the input backs up.
  initial begin : result_sink
    int                cnt;
    logic [15:0]       mask;
    bit                held;
    cnt  = 0;
    mask = '1;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && results_seen >= BACKPRESSURE_AFTER) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        for (int c = 0; c < BACKPRESSURE_CYCLES; c++) @(posedge clk);
      end
      if (cnt == 0) begin
        cnt  = 128;
        mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      end
      out_ch.ready <= mask[cnt % 16];
      cnt--;
      @(posedge clk);
    end
  end

  // Result checker: every accepted result transaction against the oldest
  // expectation, field by field.
  always @(posedge clk) begin : result_check
    estimate_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_estimates.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual estimate %0d dbz %0b",
                 $time, out_ch.estimate, out_ch.divide_by_zero);
      end else begin
        want = pending_estimates.pop_front();
        if (out_ch.estimate !== want.estimate) begin
          mismatches++;
          $display("%0t: estimate mismatch, expected %0d, actual %0d",
                   $time, want.estimate, out_ch.estimate);
        end
        if (out_ch.divide_by_zero !== want.divide_by_zero) begin
          mismatches++;
          $display("%0t: divide_by_zero mismatch, expected %0b, actual %0b",
                   $time, want.divide_by_zero, out_ch.divide_by_zero);
        end
      end
    end
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/lmee_pkg.sv
rtl/core/lmee_ifs.sv
rtl/core/lmee_div.sv
rtl/core/level_median_expression_estimator_unit.sv
tb/sv/tb_level_median_expression_estimator_unit.sv
